/* hw/rtl/ihss_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and byte constants for the image header size sniffer
package ihss_pkg;

  localparam int unsigned POSITION_WIDTH_DEF = 32;
  localparam int unsigned HEADER_LEN         = 24;
  localparam int unsigned HDR_IDX_W          = 5;
  localparam int unsigned IN_TDATA_W         = 8;
  localparam int unsigned OUT_TDATA_W        = 72;

  typedef enum logic [2:0] {
    FMT_NONE = 3'd0,
    FMT_JFIF = 3'd1,
    FMT_JPEG = 3'd2,
    FMT_GIF  = 3'd3,
    FMT_PNG  = 3'd4
  } img_fmt_t;

  typedef struct packed {
    logic        failed;
    img_fmt_t    image_format;
    logic [31:0] width;
    logic [31:0] height;
  } ihss_result_t;

  localparam logic [7:0] B_FF   = 8'hFF;
  localparam logic [7:0] B_D8   = 8'hD8;
  localparam logic [7:0] B_E0   = 8'hE0;
  localparam logic [7:0] B_C0   = 8'hC0;
  localparam logic [7:0] B_89   = 8'h89;
  localparam logic [7:0] B_CR   = 8'h0D;
  localparam logic [7:0] B_LF   = 8'h0A;
  localparam logic [7:0] B_SUB  = 8'h1A;
  localparam logic [7:0] B_NUL  = 8'h00;
  localparam logic [7:0] CH_J   = 8'h4A;
  localparam logic [7:0] CH_F   = 8'h46;
  localparam logic [7:0] CH_I   = 8'h49;
  localparam logic [7:0] CH_G   = 8'h47;
  localparam logic [7:0] CH_P   = 8'h50;
  localparam logic [7:0] CH_N   = 8'h4E;
  localparam logic [7:0] CH_H   = 8'h48;
  localparam logic [7:0] CH_D   = 8'h44;
  localparam logic [7:0] CH_R   = 8'h52;

  function automatic ihss_result_t make_result(img_fmt_t fmt, logic [31:0] w, logic [31:0] h);
    ihss_result_t r;
    r.failed       = (fmt == FMT_NONE);
    r.image_format = fmt;
    r.width        = (fmt == FMT_NONE) ? 32'd0 : w;
    r.height       = (fmt == FMT_NONE) ? 32'd0 : h;
    return r;
  endfunction

endpackage

/* hw/rtl/image_header_size_sniffer_unit.sv */
`timescale 1ns / 1ps
// top level: input item register, header parser and result register
// a result is computed from the item in the input register and held in the result register
// throughput: one byte per cycle while out_tready is high; set by the input and result registers
// a pending result stalls the input only when the result register is full and not taken
// reset: synchronous active-low rst_n clears the file position, walk state and both valid flags
module image_header_size_sniffer_unit #(
  parameter int unsigned POSITION_WIDTH = ihss_pkg::POSITION_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ihss_pkg::IN_TDATA_W-1:0]    in_tdata,   // [7:0] data_byte
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ihss_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [2:0] image_format, [34:3] width,
                                                         // [66:35] height, [71:67] zero
  output logic                               out_tuser   // [0] failed
);
  import ihss_pkg::*;

  logic         in_valid_r;
  logic [7:0]   in_byte_r;
  logic         in_eof_r;
  logic         out_valid_r;
  ihss_result_t out_res_r;
  logic         adv;
  logic         step;
  logic         res_valid;
  ihss_result_t res;

  assign adv       = !out_valid_r || out_tready;
  assign step      = in_valid_r && adv;
  assign in_tready = !in_valid_r || adv;

  ihss_parser #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_i       (step),
    .data_byte_i  (in_byte_r),
    .end_of_file_i(in_eof_r),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (step && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_byte_r <= in_tdata[7:0];
      in_eof_r  <= in_tlast;
    end
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r.height, out_res_r.width, out_res_r.image_format};
  assign out_tuser  = out_res_r.failed;

endmodule

/* hw/rtl/ihss_parser.sv */
`timescale 1ns / 1ps
// per-file header store, jpeg segment walk and format decision
module ihss_parser #(
  parameter int unsigned POSITION_WIDTH = ihss_pkg::POSITION_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  end_of_file_i,
  output logic                  res_valid_o,
  output ihss_pkg::ihss_result_t res_o
);
  import ihss_pkg::*;

  typedef enum logic [3:0] {
    SP_WAIT   = 4'd0,
    SP_SEEK   = 4'd1,
    SP_MARK   = 4'd2,
    SP_LEN_HI = 4'd3,
    SP_LEN_LO = 4'd4,
    SP_SOF_L1 = 4'd5,
    SP_SOF_L2 = 4'd6,
    SP_SOF_P  = 4'd7,
    SP_H_HI   = 4'd8,
    SP_H_LO   = 4'd9,
    SP_W_HI   = 4'd10,
    SP_W_LO   = 4'd11,
    SP_OK     = 4'd12,
    SP_FAIL   = 4'd13
  } seg_phase_t;

  logic [7:0]                hdr_r [HEADER_LEN];
  logic [7:0]                hv    [HEADER_LEN];
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic [POSITION_WIDTH-1:0] nsp_r, nsp_nxt;
  seg_phase_t                phase_r, phase_nxt, phase_eff;
  logic                      parse_r, parse_nxt;
  logic [15:0]               ch_r, ch_nxt;
  logic [15:0]               cw_r, cw_nxt;
  logic                      rg_r, rg_nxt;
  logic [15:0]               seg_len;
  logic [POSITION_WIDTH:0]   seg_sum;
  logic                      pos_last_hdr;
  logic                      is_jfif, is_jpeg, is_gif, is_png;

  assign pos_last_hdr = (pos_r == POSITION_WIDTH'(HEADER_LEN - 1));
  assign seg_len      = {cw_r[7:0], data_byte_i};
  assign seg_sum      = {1'b0, pos_r} + (POSITION_WIDTH + 1)'(seg_len - 16'd1);

  always_comb begin
    for (int i = 0; i < HEADER_LEN - 1; i++) begin
      hv[i] = hdr_r[i];
    end
    hv[HEADER_LEN-1] = pos_last_hdr ? data_byte_i : hdr_r[HEADER_LEN-1];
  end

  assign is_jpeg = (hv[0] == B_FF) && (hv[1] == B_D8) && (hv[2] == B_FF);
  assign is_jfif = is_jpeg && (hv[3] == B_E0) && (hv[6] == CH_J) && (hv[7] == CH_F)
                   && (hv[8] == CH_I) && (hv[9] == CH_F) && (hv[10] == B_NUL);
  assign is_gif  = (hv[0] == CH_G) && (hv[1] == CH_I) && (hv[2] == CH_F);
  assign is_png  = (hv[0] == B_89) && (hv[1] == CH_P) && (hv[2] == CH_N) && (hv[3] == CH_G)
                   && (hv[4] == B_CR) && (hv[5] == B_LF) && (hv[6] == B_SUB) && (hv[7] == B_LF)
                   && (hv[12] == CH_I) && (hv[13] == CH_H) && (hv[14] == CH_D)
                   && (hv[15] == CH_R);

  always_comb begin
    pos_nxt     = pos_r;
    nsp_nxt     = nsp_r;
    phase_nxt   = phase_r;
    parse_nxt   = parse_r;
    ch_nxt      = ch_r;
    cw_nxt      = cw_r;
    rg_nxt      = rg_r;
    res_valid_o = 1'b0;
    res_o       = make_result(FMT_NONE, 32'd0, 32'd0);
    phase_eff   = (phase_r == SP_WAIT && pos_r == POSITION_WIDTH'(4)) ? SP_LEN_HI : phase_r;
    if (step_i) begin
      if (!rg_r) begin
        parse_nxt = parse_r | pos_last_hdr;
        case (phase_eff)
          SP_SEEK: begin
            if (pos_r == nsp_r) begin
              phase_nxt = (data_byte_i == B_FF) ? SP_MARK : SP_FAIL;
            end
          end
          SP_MARK:   phase_nxt = (data_byte_i == B_C0) ? SP_SOF_L1 : SP_LEN_HI;
          SP_LEN_HI: begin
            cw_nxt    = {8'd0, data_byte_i};
            phase_nxt = SP_LEN_LO;
          end
          SP_LEN_LO: begin
            cw_nxt = 16'd0;
            if (seg_len < 16'd2 || seg_sum[POSITION_WIDTH]) begin
              phase_nxt = SP_FAIL;
            end else begin
              nsp_nxt   = seg_sum[POSITION_WIDTH-1:0];
              phase_nxt = SP_SEEK;
            end
          end
          SP_SOF_L1: phase_nxt = SP_SOF_L2;
          SP_SOF_L2: phase_nxt = SP_SOF_P;
          SP_SOF_P:  phase_nxt = SP_H_HI;
          SP_H_HI: begin
            ch_nxt    = {data_byte_i, 8'd0};
            phase_nxt = SP_H_LO;
          end
          SP_H_LO: begin
            ch_nxt    = {ch_r[15:8], data_byte_i};
            phase_nxt = SP_W_HI;
          end
          SP_W_HI: begin
            cw_nxt    = {data_byte_i, 8'd0};
            phase_nxt = SP_W_LO;
          end
          SP_W_LO: begin
            cw_nxt    = {cw_r[15:8], data_byte_i};
            phase_nxt = SP_OK;
          end
          default: phase_nxt = phase_eff;
        endcase

        if (!parse_nxt) begin
          if (end_of_file_i) begin
            res_valid_o = 1'b1;
          end
        end else if (is_jfif) begin
          if (phase_nxt == SP_OK) begin
            res_valid_o = 1'b1;
            res_o = make_result(FMT_JFIF, {16'd0, cw_nxt}, {16'd0, ch_nxt});
          end else if (phase_nxt == SP_FAIL || end_of_file_i) begin
            res_valid_o = 1'b1;
          end
        end else if (is_jpeg) begin
          res_valid_o = 1'b1;
          res_o = make_result(FMT_JPEG, {16'd0, hv[9], hv[10]}, {16'd0, hv[7], hv[8]});
        end else if (is_gif) begin
          res_valid_o = 1'b1;
          res_o = make_result(FMT_GIF, {16'd0, hv[7], hv[6]}, {16'd0, hv[9], hv[8]});
        end else if (is_png) begin
          res_valid_o = 1'b1;
          res_o = make_result(FMT_PNG, {hv[16], hv[17], hv[18], hv[19]},
                              {hv[20], hv[21], hv[22], hv[23]});
        end else begin
          res_valid_o = 1'b1;
        end
        if (res_valid_o) begin
          rg_nxt = 1'b1;
        end
      end

      if (pos_r != {POSITION_WIDTH{1'b1}}) begin
        pos_nxt = pos_r + POSITION_WIDTH'(1);
      end

      if (end_of_file_i) begin
        pos_nxt   = '0;
        nsp_nxt   = '0;
        phase_nxt = SP_WAIT;
        parse_nxt = 1'b0;
        ch_nxt    = 16'd0;
        cw_nxt    = 16'd0;
        rg_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      nsp_r   <= '0;
      phase_r <= SP_WAIT;
      parse_r <= 1'b0;
      ch_r    <= 16'd0;
      cw_r    <= 16'd0;
      rg_r    <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      nsp_r   <= nsp_nxt;
      phase_r <= phase_nxt;
      parse_r <= parse_nxt;
      ch_r    <= ch_nxt;
      cw_r    <= cw_nxt;
      rg_r    <= rg_nxt;
    end
  end

  // header bytes, written in arrival order
  always_ff @(posedge clk) begin
    if (step_i && !rg_r && pos_r < POSITION_WIDTH'(HEADER_LEN)) begin
      hdr_r[pos_r[HDR_IDX_W-1:0]] <= data_byte_i;
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// testbench for the image header size sniffer: directed and random image files against a size predictor

import ihss_pkg::*;

typedef enum bit [3:0] {
  WK_WAIT, WK_SEEK, WK_MARK, WK_LEN_HI, WK_LEN_LO, WK_SOF_L1, WK_SOF_L2, WK_SOF_P,
  WK_H_HI, WK_H_LO, WK_W_HI, WK_W_LO, WK_OK, WK_FAIL
} walk_phase_t;

class header_size_board;
  localparam bit [63:0] POS_MAX = (64'd1 << POSITION_WIDTH_DEF) - 64'd1;

  ihss_result_t due_sizes[$];
  int           errors;
  bit [7:0]     hdr[HEADER_LEN];
  bit [63:0]    pos;
  bit [63:0]    seg_pos;
  walk_phase_t  walk;
  bit           hdr_held;
  bit [31:0]    cap_h;
  bit [31:0]    cap_w;
  bit           given;

  function new();
    errors = 0;
    foreach (hdr[i]) hdr[i] = 8'h00;
    clear_file();
  endfunction

  function void clear_file();
    pos      = 64'd0;
    seg_pos  = 64'd0;
    walk     = WK_WAIT;
    hdr_held = 1'b0;
    cap_h    = 32'd0;
    cap_w    = 32'd0;
    given    = 1'b0;
  endfunction

  function void add_size(img_fmt_t fmt, bit [31:0] w, bit [31:0] h);
    ihss_result_t r;
    r.failed       = (fmt == FMT_NONE);
    r.image_format = fmt;
    r.width        = (fmt == FMT_NONE) ? 32'd0 : w;
    r.height       = (fmt == FMT_NONE) ? 32'd0 : h;
    due_sizes.push_back(r);
    given = 1'b1;
  endfunction

  function void walk_byte(bit [63:0] p, bit [7:0] b);
    bit [63:0] seg_len;
    bit [63:0] nxt;
    if (walk == WK_WAIT && p == 64'd4) walk = WK_LEN_HI;
    case (walk)
      WK_SEEK: begin
        if (p == seg_pos) walk = (b == B_FF) ? WK_MARK : WK_FAIL;
      end
      WK_MARK: walk = (b == B_C0) ? WK_SOF_L1 : WK_LEN_HI;
      WK_LEN_HI: begin
        cap_w = {24'd0, b};
        walk  = WK_LEN_LO;
      end
      WK_LEN_LO: begin
        seg_len = {48'd0, cap_w[7:0], b};
        cap_w   = 32'd0;
        nxt     = p - 64'd1 + seg_len;
        if (seg_len < 64'd2 || nxt < p || nxt > POS_MAX) begin
          walk = WK_FAIL;
        end else begin
          seg_pos = nxt;
          walk    = WK_SEEK;
        end
      end
      WK_SOF_L1: walk = WK_SOF_L2;
      WK_SOF_L2: walk = WK_SOF_P;
      WK_SOF_P:  walk = WK_H_HI;
      WK_H_HI: begin
        cap_h = {16'd0, b, 8'd0};
        walk  = WK_H_LO;
      end
      WK_H_LO: begin
        cap_h = cap_h | {24'd0, b};
        walk  = WK_W_HI;
      end
      WK_W_HI: begin
        cap_w = {16'd0, b, 8'd0};
        walk  = WK_W_LO;
      end
      WK_W_LO: begin
        cap_w = cap_w | {24'd0, b};
        walk  = WK_OK;
      end
      default: ;
    endcase
  endfunction

  // returns 1 when the byte still mattered for this file
  function bit note_byte(bit [7:0] b, bit last);
    bit [63:0] p;
    bit        used;
    p    = pos;
    used = !given;
    if (!given) begin
      if (p < HEADER_LEN) hdr[p[4:0]] = b;
      if (p == HEADER_LEN - 1) hdr_held = 1'b1;
      walk_byte(p, b);
      if (!hdr_held) begin
        if (last) add_size(FMT_NONE, 32'd0, 32'd0);
      end else if (hdr[0] == B_FF && hdr[1] == B_D8 && hdr[2] == B_FF && hdr[3] == B_E0 &&
                   hdr[6] == CH_J && hdr[7] == CH_F && hdr[8] == CH_I && hdr[9] == CH_F &&
                   hdr[10] == B_NUL) begin
        if (walk == WK_OK)
          add_size(FMT_JFIF, {16'd0, cap_w[15:0]}, {16'd0, cap_h[15:0]});
        else if (walk == WK_FAIL || last)
          add_size(FMT_NONE, 32'd0, 32'd0);
      end else if (hdr[0] == B_FF && hdr[1] == B_D8 && hdr[2] == B_FF) begin
        add_size(FMT_JPEG, {16'd0, hdr[9], hdr[10]}, {16'd0, hdr[7], hdr[8]});
      end else if (hdr[0] == CH_G && hdr[1] == CH_I && hdr[2] == CH_F) begin
        add_size(FMT_GIF, {16'd0, hdr[7], hdr[6]}, {16'd0, hdr[9], hdr[8]});
      end else if (hdr[0] == B_89 && hdr[1] == CH_P && hdr[2] == CH_N && hdr[3] == CH_G &&
                   hdr[4] == B_CR && hdr[5] == B_LF && hdr[6] == B_SUB && hdr[7] == B_LF &&
                   hdr[12] == CH_I && hdr[13] == CH_H && hdr[14] == CH_D &&
                   hdr[15] == CH_R) begin
        add_size(FMT_PNG, {hdr[16], hdr[17], hdr[18], hdr[19]},
                 {hdr[20], hdr[21], hdr[22], hdr[23]});
      end else begin
        add_size(FMT_NONE, 32'd0, 32'd0);
      end
    end
    if (pos < POS_MAX) pos = pos + 64'd1;
    if (last) clear_file();
    return used;
  endfunction

  task report_mismatch(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_result(logic [OUT_TDATA_W-1:0] td, logic tu);
    ihss_result_t e;
    if (due_sizes.size() == 0) begin
      report_mismatch("result with nothing expected");
    end else begin
      e = due_sizes.pop_front();
      if (tu !== e.failed)
        report_mismatch($sformatf("failed: got %b, want %b", tu, e.failed));
      if (td[2:0] !== e.image_format)
        report_mismatch($sformatf("format: got %0d, want %0d", td[2:0], e.image_format));
      if (td[34:3] !== e.width)
        report_mismatch($sformatf("width: got %0h, want %0h", td[34:3], e.width));
      if (td[66:35] !== e.height)
        report_mismatch($sformatf("height: got %0h, want %0h", td[66:35], e.height));
    end
  endtask
endclass

module tb_top;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_BYTES    = 250;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  header_size_board sizes;
  bit [7:0]         file_bytes[$];
  int               idle_pct;
  int               stall_pct;
  int               parsed_bytes;
  int               quiet_cycles;
  bit               run_done;

  image_header_size_sniffer_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      if (sizes.note_byte(in_tdata, in_tlast)) parsed_bytes++;
    end
    if (rst_n && out_tvalid && out_tready) sizes.check_result(out_tdata, out_tuser);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT && !run_done) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  task send_byte(bit [7:0] b, bit last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task send_file();
    for (int i = 0; i < file_bytes.size(); i++) send_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  task add_random(int n);
    repeat (n) file_bytes.push_back(8'($urandom));
  endtask

  task trim_to(int n);
    while (file_bytes.size() > n) void'(file_bytes.pop_back());
  endtask

  task build_jfif(bit [15:0] w, bit [15:0] h);
    int app_len;
    int seg_len;
    bit [7:0] marker;
    app_len    = $urandom_range(16, 24);
    file_bytes = {B_FF, B_D8, B_FF, B_E0, 8'(app_len >> 8), 8'(app_len),
                  CH_J, CH_F, CH_I, CH_F, B_NUL};
    add_random(app_len - 7);
    repeat ($urandom_range(0, 3)) begin
      marker  = 8'($urandom_range(0, 255));
      if (marker == B_C0) marker = 8'hC4;
      seg_len = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 300) : $urandom_range(2, 12);
      file_bytes.push_back(B_FF);
      file_bytes.push_back(marker);
      file_bytes.push_back(8'(seg_len >> 8));
      file_bytes.push_back(8'(seg_len));
      add_random(seg_len - 2);
    end
    file_bytes = {file_bytes, B_FF, B_C0, 8'h00, 8'h11, 8'h08, h[15:8], h[7:0], w[15:8], w[7:0]};
    add_random($urandom_range(0, 6));
    if (file_bytes.size() < HEADER_LEN) add_random(HEADER_LEN - file_bytes.size());
  endtask

  task build_broken_jfif();
    int sel;
    int idx;
    build_jfif(16'($urandom), 16'($urandom));
    sel = $urandom_range(0, 3);
    case (sel)
      0: begin
        file_bytes[4] = 8'h00;
        file_bytes[5] = 8'($urandom_range(0, 1));
      end
      1: begin
        idx = $urandom_range(11, file_bytes.size() - 1);
        file_bytes[idx] = 8'($urandom);
      end
      2: trim_to($urandom_range(HEADER_LEN, file_bytes.size() - 1));
      default: begin
        idx = 4 + {file_bytes[4], file_bytes[5]};
        file_bytes[idx] = 8'($urandom_range(0, 254));
      end
    endcase
  endtask

  task build_jpeg();
    file_bytes = {B_FF, B_D8, B_FF};
    add_random($urandom_range(21, 30));
  endtask

  task build_gif();
    file_bytes = {CH_G, CH_I, CH_F};
    add_random($urandom_range(21, 30));
  endtask

  task build_png();
    file_bytes = {B_89, CH_P, CH_N, CH_G, B_CR, B_LF, B_SUB, B_LF};
    add_random(4);
    file_bytes = {file_bytes, CH_I, CH_H, CH_D, CH_R};
    add_random(8 + $urandom_range(0, 4));
  endtask

  task build_any();
    case ($urandom_range(0, 4))
      0: build_jfif(16'($urandom), 16'($urandom));
      1: build_jpeg();
      2: build_gif();
      3: build_png();
      default: build_broken_jfif();
    endcase
  endtask

  task build_noise();
    int idx;
    if ($urandom_range(0, 1) == 0) begin
      file_bytes = {};
      add_random($urandom_range(1, 35));
    end else begin
      build_any();
      idx = $urandom_range(0, 15);
      file_bytes[idx] = file_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
    end
  endtask

  task run_directed();
    file_bytes = {B_FF};
    send_file();
    file_bytes = {CH_G, CH_I, CH_F, 8'h38, 8'h39, 8'h61, 8'hFF, 8'hFF, 8'h00, 8'h00};
    add_random(14);
    send_file();
    file_bytes = {B_89, CH_P, CH_N, CH_G, B_CR, B_LF, B_SUB, B_LF, 8'h00, 8'h00, 8'h00, 8'h0D,
                  CH_I, CH_H, CH_D, CH_R, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  8'h00, 8'h00, 8'h00, 8'h00};
    send_file();
    file_bytes = {B_FF, B_D8, B_FF, 8'hDB, 8'h00, 8'h43, 8'h08, 8'h00, 8'h00, 8'hFF, 8'hFF};
    add_random(13);
    send_file();
    build_jfif(16'hFFFF, 16'hFFFF);
    send_file();
    build_jfif(16'h0000, 16'h0000);
    send_file();
    build_jfif(16'h1234, 16'h0567);
    file_bytes[4] = 8'h00;
    file_bytes[5] = 8'h00;
    send_file();
    build_jfif(16'h0100, 16'h0080);
    trim_to(HEADER_LEN + 1);
    send_file();
    file_bytes = {};
    repeat (HEADER_LEN) file_bytes.push_back(8'h00);
    send_file();
    build_gif();
    add_random(10);
    send_file();
  endtask

  initial begin
    int pick;
    int goal;
    sizes        = new();
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    out_tready   = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    run_done     = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      goal = parsed_bytes + PHASE_BYTES;
      while (parsed_bytes < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 30)      build_jfif(16'($urandom), 16'($urandom));
        else if (pick < 45) build_broken_jfif();
        else if (pick < 55) build_jpeg();
        else if (pick < 65) build_gif();
        else if (pick < 75) build_png();
        else if (pick < 88) build_noise();
        else begin
          build_any();
          trim_to($urandom_range(1, HEADER_LEN - 1));
        end
        send_file();
      end
    end
    in_tvalid <= 1'b0;

    while (sizes.due_sizes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    run_done = 1'b1;
    if (sizes.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule

/* image_header_size_sniffer_unit.f */
hw/rtl/ihss_pkg.sv
hw/rtl/ihss_parser.sv
hw/rtl/image_header_size_sniffer_unit.sv
tb/tb_top.sv
